@@ hdl/hbbc_pkg.sv @@
// Shared types and constants for the hashed block buffer cache.
package hbbc_pkg;

  localparam int DEV_W    = 8;
  localparam int BLK_W    = 32;
  localparam int IDX_W    = 5;
  localparam int TIME_W   = 32;
  localparam int CNT_W    = 8;
  localparam int BKT_W    = 4;
  localparam int JOIN_W   = 32;
  localparam int STAT_W   = 2;
  localparam int KIND_W   = 2;
  localparam int IN_W     = 80;
  localparam int OUT_W    = 16;
  localparam int MOD_STEPS = 3;

  localparam logic [KIND_W-1:0] KIND_READ    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PIN     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNPIN   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_COUNT   = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  typedef struct packed {
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic              valid;
    logic [CNT_W-1:0]  cnt;
    logic [TIME_W-1:0] stamp;
    logic [BKT_W-1:0]  bucket;
    logic [JOIN_W-1:0] join_ord;
  } rec_t;

  typedef struct packed {
    logic cap;
    logic mod_step;
    logic scan_rd;
    logic fetch;
    logic update;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_is_read;
    logic req_is_read;
    logic mod_done;
    logic scan_last;
  } stat_t;

endpackage

@@ hdl/hbbc_ctrl.sv @@
// Request sequencer for the hashed block buffer cache.
module hbbc_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  input  hbbc_pkg::stat_t stat,
  output hbbc_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_SCAN, S_DRAIN, S_FETCH, S_UPDATE, S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd          = '0;
    cmd.cap      = (state == S_IDLE) && s_tvalid;
    cmd.mod_step = (state == S_MOD);
    cmd.scan_rd  = (state == S_SCAN);
    cmd.fetch    = (state == S_FETCH);
    cmd.update   = (state == S_UPDATE);
    cmd.out_load = (state == S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) state <= stat.in_is_read ? S_MOD : S_FETCH;
        end
        S_MOD: begin
          if (stat.mod_done) state <= S_SCAN;
        end
        S_SCAN: begin
          if (stat.scan_last) state <= S_DRAIN;
        end
        S_DRAIN:  state <= S_FETCH;
        S_FETCH:  state <= S_UPDATE;
        S_UPDATE: state <= S_DONE;
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/hbbc_dp.sv @@
// Entry store, bucket hash, scan and update datapath of the buffer cache.
module hbbc_dp #(
  parameter int ENTRIES = 32,
  parameter int BUCKETS = 13
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [hbbc_pkg::KIND_W-1:0]  s_tuser,
  input  logic [hbbc_pkg::IN_W-1:0]    s_tdata,
  input  hbbc_pkg::cmd_t               cmd,
  output hbbc_pkg::stat_t              stat,
  output logic [hbbc_pkg::OUT_W-1:0]   m_tdata
);

  localparam int AW = $clog2(ENTRIES);
  // floor(2^32 / BUCKETS): quotient estimate is exact or one short
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(BUCKETS));

  // request
  logic [hbbc_pkg::KIND_W-1:0] req_kind;
  logic [hbbc_pkg::DEV_W-1:0]  req_dev;
  logic [hbbc_pkg::BLK_W-1:0]  req_blk;
  logic [hbbc_pkg::IDX_W-1:0]  req_idx;
  logic [hbbc_pkg::TIME_W-1:0] req_now;

  // bucket hash by reciprocal multiplication, three steps
  logic [63:0]                 prod;
  logic [31:0]                 quot;
  logic [31:0]                 qb;
  logic [5:0]                  rem;
  logic [hbbc_pkg::BKT_W-1:0]  bk;
  logic [4:0]                  mod_cnt;

  // store
  hbbc_pkg::rec_t              mem [ENTRIES];
  logic [ENTRIES-1:0]          init;
  hbbc_pkg::rec_t              rd_data;
  logic                        rd_init;
  logic [AW-1:0]               rd_idx;
  logic [AW-1:0]               rd_addr;
  logic                        rd_en;
  hbbc_pkg::rec_t              cur;

  logic [AW-1:0]               scan_addr;
  logic                        ev;

  // running selections
  logic                          hit_f, own_f, oth_f;
  logic [AW-1:0]                 hit_idx, own_idx, oth_idx;
  logic [hbbc_pkg::JOIN_W-1:0]   hit_join, own_join, oth_join;
  logic [hbbc_pkg::TIME_W-1:0]   own_stamp, oth_stamp;
  logic [hbbc_pkg::BKT_W-1:0]    oth_bk;
  logic [hbbc_pkg::JOIN_W-1:0]   next_join;

  logic                          is_hit, is_own, is_oth;
  logic                          sel_found;
  logic [AW-1:0]                 sel_addr;
  logic                          in_range;

  // update
  hbbc_pkg::rec_t                wr_rec;
  logic                          wr_en;
  logic                          join_bump;
  logic [hbbc_pkg::IDX_W-1:0]    new_entry;
  logic                          new_need, new_hit;
  logic [hbbc_pkg::STAT_W-1:0]   new_status;

  logic [hbbc_pkg::IDX_W-1:0]    res_entry;
  logic                          res_need, res_hit;
  logic [hbbc_pkg::STAT_W-1:0]   res_status;

  assign stat.in_is_read  = (s_tuser == hbbc_pkg::KIND_READ);
  assign stat.req_is_read = (req_kind == hbbc_pkg::KIND_READ);
  assign stat.mod_done    = (mod_cnt == 5'(hbbc_pkg::MOD_STEPS - 1));
  assign stat.scan_last   = (scan_addr == AW'(ENTRIES - 1));

  assign prod = 64'(req_blk) * 64'(RECIP);
  assign qb   = quot * 32'(BUCKETS);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_kind <= s_tuser;
      req_dev  <= s_tdata[7:0];
      req_blk  <= s_tdata[39:8];
      req_idx  <= s_tdata[44:40];
      req_now  <= s_tdata[76:45];
      mod_cnt  <= '0;
    end else if (cmd.mod_step) begin
      mod_cnt <= mod_cnt + 5'd1;
      if (mod_cnt == 5'd0)
        quot <= prod[63:32];
      else if (mod_cnt == 5'd1)
        rem <= 6'(req_blk - qb);
      else if (rem >= 6'(BUCKETS))
        bk <= hbbc_pkg::BKT_W'(rem - 6'(BUCKETS));
      else
        bk <= hbbc_pkg::BKT_W'(rem);
    end
  end

  // entry not yet written reads as its reset value
  always_comb begin
    if (rd_init) begin
      cur = rd_data;
    end else begin
      cur          = '0;
      cur.join_ord = hbbc_pkg::JOIN_W'(rd_idx);
    end
  end

  assign is_hit    = hit_f;
  assign is_own    = !hit_f && own_f;
  assign is_oth    = !hit_f && !own_f && oth_f;
  assign sel_found = hit_f || own_f || oth_f;
  assign sel_addr  = hit_f ? hit_idx : (own_f ? own_idx : oth_idx);
  assign in_range  = ({4'b0, req_idx} < 9'(ENTRIES));

  assign rd_en   = cmd.scan_rd || cmd.fetch;
  assign rd_addr = cmd.scan_rd ? scan_addr
                 : (stat.req_is_read ? sel_addr : AW'(req_idx));

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_idx  <= rd_addr;
    end
    if (wr_en) mem[rd_idx] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init      <= '0;
      rd_init   <= 1'b0;
      next_join <= hbbc_pkg::JOIN_W'(ENTRIES);
      ev        <= 1'b0;
    end else begin
      ev <= cmd.scan_rd;
      if (rd_en) rd_init <= init[rd_addr];
      if (wr_en) init[rd_idx] <= 1'b1;
      if (join_bump) next_join <= next_join + hbbc_pkg::JOIN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      scan_addr <= '0;
      hit_f     <= 1'b0;
      own_f     <= 1'b0;
      oth_f     <= 1'b0;
    end else begin
      if (cmd.scan_rd) scan_addr <= scan_addr + AW'(1);
      if (ev) begin
        if (cur.bucket == bk && cur.dev == req_dev && cur.blk == req_blk &&
            (!hit_f || cur.join_ord < hit_join)) begin
          hit_f    <= 1'b1;
          hit_idx  <= rd_idx;
          hit_join <= cur.join_ord;
        end
        if (cur.bucket == bk && cur.cnt == '0 &&
            (!own_f || cur.stamp < own_stamp ||
             (cur.stamp == own_stamp && cur.join_ord < own_join))) begin
          own_f     <= 1'b1;
          own_idx   <= rd_idx;
          own_stamp <= cur.stamp;
          own_join  <= cur.join_ord;
        end
        // lowest other bucket first, then oldest stamp, then earliest join
        if (cur.bucket != bk && cur.cnt == '0 &&
            (!oth_f || cur.bucket < oth_bk ||
             (cur.bucket == oth_bk && (cur.stamp < oth_stamp ||
              (cur.stamp == oth_stamp && cur.join_ord < oth_join))))) begin
          oth_f     <= 1'b1;
          oth_idx   <= rd_idx;
          oth_bk    <= cur.bucket;
          oth_stamp <= cur.stamp;
          oth_join  <= cur.join_ord;
        end
      end
    end
  end

  always_comb begin
    wr_rec     = cur;
    wr_en      = 1'b0;
    join_bump  = 1'b0;
    new_entry  = req_idx;
    new_need   = 1'b0;
    new_hit    = 1'b0;
    new_status = hbbc_pkg::ST_OK;
    if (cmd.update) begin
      if (stat.req_is_read) begin
        if (!sel_found) begin
          new_entry  = '0;
          new_status = hbbc_pkg::ST_NO_FREE;
        end else begin
          wr_en     = 1'b1;
          new_entry = hbbc_pkg::IDX_W'(rd_idx);
          if (is_hit) begin
            new_hit  = 1'b1;
            new_need = !cur.valid;
            if (cur.cnt == hbbc_pkg::CNT_MAX) new_status = hbbc_pkg::ST_COUNT;
            else wr_rec.cnt = cur.cnt + hbbc_pkg::CNT_W'(1);
          end else begin
            new_need   = 1'b1;
            wr_rec.dev = req_dev;
            wr_rec.blk = req_blk;
            wr_rec.cnt = hbbc_pkg::CNT_W'(1);
            if (is_oth) begin
              wr_rec.bucket   = bk;
              wr_rec.join_ord = next_join;
              join_bump       = 1'b1;
            end
          end
          wr_rec.valid = 1'b1;
        end
      end else if (in_range) begin
        wr_en = 1'b1;
        if (req_kind == hbbc_pkg::KIND_PIN) begin
          if (cur.cnt == hbbc_pkg::CNT_MAX) new_status = hbbc_pkg::ST_COUNT;
          else wr_rec.cnt = cur.cnt + hbbc_pkg::CNT_W'(1);
        end else if (cur.cnt == '0) begin
          new_status = hbbc_pkg::ST_COUNT;
        end else begin
          wr_rec.cnt = cur.cnt - hbbc_pkg::CNT_W'(1);
          if (req_kind == hbbc_pkg::KIND_RELEASE && cur.cnt == hbbc_pkg::CNT_W'(1))
            wr_rec.stamp = req_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      res_entry  <= new_entry;
      res_need   <= new_need;
      res_hit    <= new_hit;
      res_status <= new_status;
    end
    if (cmd.out_load) begin
      m_tdata <= {7'b0, res_status, res_hit, res_need, res_entry};
    end
  end

endmodule

@@ hdl/hashed_block_buffer_cache.sv @@
// Top level of the hashed block buffer cache tag and replacement manager.
//
// Slave channel (s_*) takes one request: tuser carries the kind (read,
// release, pin, unpin), tdata the device, block number, entry index and time.
// Master channel (m_*) returns exactly one response per request.
//
// A read first hashes the block number into its bucket by a reciprocal
// multiply and correction, then scans the entry store one entry a cycle
// through its single read port, tracking the hit, the best free entry of
// the own bucket and of the lowest other bucket.
// Then the chosen entry is fetched and rewritten. A release, pin or unpin
// skips the hash and the scan and goes straight to the fetch and rewrite
// of the indexed entry; the next request is taken once the response is loaded.
// One request is worked on at a time; s_tready is high only while idle.
// The response sits in an output register, so a new request is taken while
// it waits; a stalled m_tready only holds the next response back.
// Reset (rst, synchronous) empties the store at once: per-entry init flags
// make unwritten entries read as their reset values, no clearing pass.
module hashed_block_buffer_cache #(
  parameter int ENTRIES = 32,
  parameter int BUCKETS = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // kind
  input  logic [79:0] s_tdata,   // dev[7:0], block_number[39:8], entry_index[44:40], now[76:45]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // entry[4:0], need_read[5], hit[6], status[8:7]
);

  hbbc_pkg::cmd_t  cmd;
  hbbc_pkg::stat_t stat;

  hbbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hbbc_dp #(
    .ENTRIES (ENTRIES),
    .BUCKETS (BUCKETS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tuser (s_tuser),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .stat    (stat),
    .m_tdata (m_tdata)
  );

endmodule
